// File: rtl/bba_pkg.sv
// ----------------------------------------------------------------------------
// bba_pkg
// Shared constants and types of the buddy block allocator.
// ----------------------------------------------------------------------------
package bba_pkg;

	localparam int MAX_EXP_DEF = 20;
	localparam int MIN_EXP_DEF = 4;

	localparam int EXP_W  = 5;
	localparam int ADDR_W = 32;
	localparam int CNT_W  = 16;

	typedef enum logic [1:0] {
		CMD_ALLOC = 2'd0,
		CMD_FREE  = 2'd1,
		CMD_QUERY = 2'd2,
		CMD_NONE  = 2'd3
	} cmd_t;

	typedef enum logic [1:0] {
		STS_OK       = 2'd0,
		STS_NOMEM    = 2'd1,
		STS_INVALID  = 2'd2,
		STS_NOT_BASE = 2'd3
	} status_t;

	typedef enum logic [1:0] {
		CFG_BASE   = 2'd0,
		CFG_DEBUG  = 2'd1,
		CFG_STRICT = 2'd2,
		CFG_NONE   = 2'd3
	} cfg_idx_t;

	typedef enum logic [5:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_FIN,
		// block lookup
		ST_F_ROOT,
		ST_F_ROOTCK,
		ST_F_START,
		ST_F_RD,
		ST_F_CK,
		ST_F_C0,
		ST_F_C1,
		ST_F_C2,
		ST_F_HIT,
		// free and merge
		ST_M_START,
		ST_M_CHK,
		ST_M_BUD,
		ST_M_UP,
		ST_M_PUSH,
		// allocation
		ST_A_MUL,
		ST_A_NEED,
		ST_A_LVL,
		ST_A_SRCH,
		ST_A_SPLITCHK,
		ST_A_SPLIT0,
		ST_A_SPLIT1,
		ST_A_SPLIT2,
		ST_A_SPLIT3,
		ST_A_TAKE,
		ST_A_MARK,
		// free list unlink and push
		ST_P_RD,
		ST_P_WR,
		ST_U_WR0,
		ST_U_WR1
	} state_t;

endpackage

// File: rtl/buddy_block_allocator.sv
// ----------------------------------------------------------------------------
// buddy_block_allocator
// Buddy allocator over a 2^MAX_EXP byte region with a split/used bit tree and
// one linked free list per size class.
// ----------------------------------------------------------------------------
// Usage:
// - s_* takes one command word: s_tuser is the command (alloc, free, query),
//   s_tdata holds count, size, alignment and address. s_tready is high only
//   while the sequencer is idle, so one command is worked at a time.
// - m_* returns one result word per command: status, address and block size
//   in m_tdata, the found flag in m_tuser. The result sits in an output
//   register; a stalled receiver holds it, and a finished command waits in
//   its last state until the register is free.
// - cfg_we/cfg_addr/cfg_data write region base, debug check and strict check;
//   write only while idle.
// - all work runs through one bit-tree memory port and one link memory port.
//   A lookup walks up to MAX_EXP-MIN_EXP+1 levels; an alloc finds its level,
//   searches the free lists upward and splits down level by level; a free
//   merges with its buddy level by level.
// - reset: list heads reset at once, then the tree memory is cleared one
//   entry a cycle, all 2^(MAX_EXP-MIN_EXP+1)-1 entries (131071 at the defaults),
//   with s_tready low; configuration writes are taken meanwhile.
// ----------------------------------------------------------------------------
module buddy_block_allocator #(
	parameter int MAX_EXP = bba_pkg::MAX_EXP_DEF,
	parameter int MIN_EXP = bba_pkg::MIN_EXP_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	// cfg
	input  logic        cfg_we,
	input  logic [1:0]  cfg_addr,
	input  logic [31:0] cfg_data,
	// command in
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [71:0] s_tdata,  // elem_count, elem_size, align_exp, address, zero pad
	input  logic [1:0]  s_tuser,  // command
	// result out
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [39:0] m_tdata,  // result_status, result_address, block_exp, zero pad
	output logic        m_tuser   // found
);

	localparam int LB        = MAX_EXP - MIN_EXP;
	localparam int LEVELS    = LB + 1;
	localparam int LW        = $clog2(LEVELS);
	localparam int TW        = LB + 1;
	localparam int NODES     = 1 << LB;
	localparam int TREE_SIZE = 2 * NODES - 1;
	localparam logic [TW-1:0] NODE_CNT = TW'(NODES);
	localparam logic [TW-1:0] TREE_LAST = TW'(TREE_SIZE - 1);
	localparam logic [33:0] REGION_SZ = 34'(1) << MAX_EXP;

	bba_pkg::state_t state_q, state_d, ret_q;

	// config
	logic [31:0] base_q;
	logic        dbg_q, strict_q;
	logic [31:0] base_al;

	// command
	logic [1:0]  cmd_q;
	logic [15:0] cnt_q, size_q;
	logic [4:0]  aexp_q;
	logic [31:0] addr_q;

	// work registers
	logic [TW-1:0] clr_q;
	logic [31:0]   prod_q;
	logic [33:0]   need_q;
	logic [LW-1:0] lvl_q, i_q, push_lvl_q;
	logic [LB-1:0] node_q, w_q, pop_q, push_node_q;
	logic [LB:0]   old_q;
	logic [LB:0]   heads_q [LEVELS];

	// results
	logic [1:0]  res_st_q;
	logic [31:0] res_addr_q;
	logic [4:0]  res_exp_q;
	logic        res_fd_q;
	logic        m_tvalid_q;
	logic [1:0]  out_st_q;
	logic [31:0] out_addr_q;
	logic [4:0]  out_exp_q;
	logic        out_fd_q;

	// memories
	logic          tree_mem [TREE_SIZE];
	logic [LB:0]   next_mem [NODES];
	logic [LB:0]   prev_mem [NODES];
	logic          tree_rd_q;
	logic [LB:0]   next_rd_q, prev_rd_q;
	logic [TW-1:0] tree_addr;
	logic          tree_we, tree_wd;
	logic [LB-1:0] link_raddr, next_waddr, prev_waddr;
	logic          next_we, prev_we;
	logic [LB:0]   next_wd, prev_wd;

	// combinational helpers
	logic [LW-1:0] head_idx;
	logic [LB:0]   head_rd;
	logic          full_chk;
	logic [31:0]   off, blk_base;
	logic [33:0]   need_c;
	logic [LB-1:0] lvl_bit, lvl_bit_dn, buddy;
	logic [31:0]   r_c, mask_c;

	function automatic logic [TW-1:0] tidx(input logic [LB-1:0] n, input logic [LW-1:0] l);
		tidx = (NODE_CNT >> l) - TW'(1) + {1'b0, n >> l};
	endfunction

	assign base_al    = {base_q[31:MIN_EXP], MIN_EXP'(0)};
	assign head_rd    = heads_q[head_idx];
	assign full_chk   = (cmd_q == bba_pkg::CMD_QUERY) || dbg_q;
	assign off        = addr_q - base_al;
	assign blk_base   = base_al + (32'(node_q) << MIN_EXP);
	assign lvl_bit    = LB'(1) << lvl_q;
	assign lvl_bit_dn = LB'(1) << (lvl_q - LW'(1));
	assign buddy      = node_q ^ lvl_bit;
	assign need_c     = {2'b0, prod_q} +
		((aexp_q > 5'(MIN_EXP)) ? ((34'(1) << aexp_q) - 34'(1)) : 34'(0));
	assign r_c        = blk_base;
	assign mask_c     = (32'(1) << aexp_q) - 32'(1);

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			bba_pkg::ST_CLEAR: if (clr_q == TREE_LAST) state_d = bba_pkg::ST_IDLE;
			bba_pkg::ST_IDLE: begin
				if (s_tvalid) begin
					unique case (s_tuser)
						bba_pkg::CMD_ALLOC: state_d = bba_pkg::ST_A_MUL;
						bba_pkg::CMD_FREE:  state_d = dbg_q ? bba_pkg::ST_F_ROOT
						                                    : bba_pkg::ST_F_START;
						bba_pkg::CMD_QUERY: state_d = bba_pkg::ST_F_START;
						default:            state_d = bba_pkg::ST_FIN;
					endcase
				end
			end
			bba_pkg::ST_FIN: if (!m_tvalid_q || m_tready) state_d = bba_pkg::ST_IDLE;
			bba_pkg::ST_F_ROOT: state_d = bba_pkg::ST_F_ROOTCK;
			bba_pkg::ST_F_ROOTCK: state_d = tree_rd_q ? bba_pkg::ST_F_START : bba_pkg::ST_FIN;
			bba_pkg::ST_F_START:
				state_d = (off[31:MAX_EXP] != '0) ? bba_pkg::ST_FIN : bba_pkg::ST_F_RD;
			bba_pkg::ST_F_RD: state_d = bba_pkg::ST_F_CK;
			bba_pkg::ST_F_CK: begin
				priority if (tree_rd_q)
					state_d = (full_chk && lvl_q != '0) ? bba_pkg::ST_F_C0 : bba_pkg::ST_F_HIT;
				else if (lvl_q == LW'(LB)) state_d = bba_pkg::ST_FIN;
				else state_d = bba_pkg::ST_F_RD;
			end
			bba_pkg::ST_F_C0: state_d = bba_pkg::ST_F_C1;
			bba_pkg::ST_F_C1: state_d = tree_rd_q ? bba_pkg::ST_FIN : bba_pkg::ST_F_C2;
			bba_pkg::ST_F_C2: state_d = tree_rd_q ? bba_pkg::ST_FIN : bba_pkg::ST_F_HIT;
			bba_pkg::ST_F_HIT: begin
				priority if (cmd_q == bba_pkg::CMD_QUERY) state_d = bba_pkg::ST_FIN;
				else if (strict_q && addr_q != blk_base) state_d = bba_pkg::ST_FIN;
				else state_d = bba_pkg::ST_M_START;
			end
			bba_pkg::ST_M_START: state_d = bba_pkg::ST_M_CHK;
			bba_pkg::ST_M_CHK:
				state_d = (lvl_q < LW'(LB)) ? bba_pkg::ST_M_BUD : bba_pkg::ST_M_PUSH;
			bba_pkg::ST_M_BUD: state_d = tree_rd_q ? bba_pkg::ST_M_PUSH : bba_pkg::ST_P_RD;
			bba_pkg::ST_M_UP: state_d = bba_pkg::ST_M_CHK;
			bba_pkg::ST_M_PUSH: state_d = bba_pkg::ST_U_WR0;
			bba_pkg::ST_A_MUL: state_d = bba_pkg::ST_A_NEED;
			bba_pkg::ST_A_NEED:
				state_d = ({2'b0, prod_q} > REGION_SZ || need_c > REGION_SZ)
					? bba_pkg::ST_FIN : bba_pkg::ST_A_LVL;
			bba_pkg::ST_A_LVL:
				if (need_q <= (34'(1) << (lvl_q + LW'(MIN_EXP)))) state_d = bba_pkg::ST_A_SRCH;
			bba_pkg::ST_A_SRCH: begin
				priority if (head_rd[LB]) state_d = bba_pkg::ST_A_SPLITCHK;
				else if (i_q == LW'(LB)) state_d = bba_pkg::ST_FIN;
				else state_d = bba_pkg::ST_A_SRCH;
			end
			bba_pkg::ST_A_SPLITCHK:
				state_d = (i_q > lvl_q) ? bba_pkg::ST_A_SPLIT0 : bba_pkg::ST_A_TAKE;
			bba_pkg::ST_A_SPLIT0: state_d = bba_pkg::ST_P_RD;
			bba_pkg::ST_A_SPLIT1: state_d = bba_pkg::ST_U_WR0;
			bba_pkg::ST_A_SPLIT2: state_d = bba_pkg::ST_U_WR0;
			bba_pkg::ST_A_SPLIT3: state_d = bba_pkg::ST_A_SPLITCHK;
			bba_pkg::ST_A_TAKE: state_d = bba_pkg::ST_P_RD;
			bba_pkg::ST_A_MARK: state_d = bba_pkg::ST_FIN;
			bba_pkg::ST_P_RD: state_d = bba_pkg::ST_P_WR;
			bba_pkg::ST_P_WR: state_d = ret_q;
			bba_pkg::ST_U_WR0: state_d = bba_pkg::ST_U_WR1;
			bba_pkg::ST_U_WR1: state_d = ret_q;
			default: state_d = bba_pkg::ST_IDLE;
		endcase
	end

	// memory ports and head select
	always_comb begin
		s_tready   = 1'b0;
		tree_addr  = tidx(node_q, lvl_q);
		tree_we    = 1'b0;
		tree_wd    = 1'b0;
		link_raddr = pop_q;
		next_we    = 1'b0;
		next_waddr = push_node_q;
		next_wd    = old_q;
		prev_we    = 1'b0;
		prev_waddr = push_node_q;
		prev_wd    = {1'b1, LB'(push_lvl_q)};
		head_idx   = lvl_q;
		unique case (state_q)
			bba_pkg::ST_CLEAR: begin
				tree_addr = clr_q;
				tree_we   = 1'b1;
				// block zero starts as the only entry of the top list
				if (clr_q == '0) begin
					next_we    = 1'b1;
					next_waddr = '0;
					next_wd    = '0;
					prev_we    = 1'b1;
					prev_waddr = '0;
					prev_wd    = {1'b1, LB'(LB)};
				end
			end
			bba_pkg::ST_IDLE: s_tready = 1'b1;
			bba_pkg::ST_F_ROOT: tree_addr = '0;
			bba_pkg::ST_F_C0: tree_addr = tidx(node_q, lvl_q - LW'(1));
			bba_pkg::ST_F_C1: tree_addr = tidx(node_q ^ lvl_bit_dn, lvl_q - LW'(1));
			bba_pkg::ST_M_START: tree_we = 1'b1;
			bba_pkg::ST_M_CHK: tree_addr = tidx(buddy, lvl_q);
			bba_pkg::ST_M_UP: begin
				tree_addr = tidx(node_q & ~lvl_bit, lvl_q + LW'(1));
				tree_we   = 1'b1;
			end
			bba_pkg::ST_A_SRCH: head_idx = i_q;
			bba_pkg::ST_A_SPLIT0: begin
				head_idx  = i_q;
				tree_addr = tidx(head_rd[LB-1:0], i_q);
				tree_we   = 1'b1;
				tree_wd   = 1'b1;
			end
			bba_pkg::ST_A_MARK: begin
				tree_we = 1'b1;
				tree_wd = 1'b1;
			end
			bba_pkg::ST_P_WR: begin
				// unlink: predecessor or list head gets next, successor gets prev
				if (!prev_rd_q[LB]) begin
					next_we    = 1'b1;
					next_waddr = prev_rd_q[LB-1:0];
					next_wd    = next_rd_q;
				end
				if (next_rd_q[LB]) begin
					prev_we    = 1'b1;
					prev_waddr = next_rd_q[LB-1:0];
					prev_wd    = prev_rd_q;
				end
			end
			bba_pkg::ST_U_WR0: begin
				head_idx = push_lvl_q;
				next_we  = 1'b1;
				next_wd  = head_rd;
				prev_we  = 1'b1;
			end
			bba_pkg::ST_U_WR1: begin
				if (old_q[LB]) begin
					prev_we    = 1'b1;
					prev_waddr = old_q[LB-1:0];
					prev_wd    = {1'b0, push_node_q};
				end
			end
			default: ;
		endcase
	end

	// memories
	always_ff @(posedge clk) begin
		if (tree_we) tree_mem[tree_addr] <= tree_wd;
		tree_rd_q <= tree_mem[tree_addr];
	end

	always_ff @(posedge clk) begin
		if (next_we) next_mem[next_waddr] <= next_wd;
		next_rd_q <= next_mem[link_raddr];
	end

	always_ff @(posedge clk) begin
		if (prev_we) prev_mem[prev_waddr] <= prev_wd;
		prev_rd_q <= prev_mem[link_raddr];
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= bba_pkg::ST_CLEAR;
			ret_q      <= bba_pkg::ST_IDLE;
			clr_q      <= '0;
			m_tvalid_q <= 1'b0;
			base_q     <= '0;
			dbg_q      <= 1'b0;
			strict_q   <= 1'b0;
			for (int k = 0; k < LEVELS; k++) heads_q[k] <= '0;
			heads_q[LB] <= {1'b1, LB'(0)};
		end else begin
			state_q <= state_d;
			if (cfg_we) begin
				unique case (cfg_addr)
					bba_pkg::CFG_BASE:   base_q   <= cfg_data;
					bba_pkg::CFG_DEBUG:  dbg_q    <= cfg_data[0];
					bba_pkg::CFG_STRICT: strict_q <= cfg_data[0];
					default: ;
				endcase
			end
			if (state_q == bba_pkg::ST_CLEAR) clr_q <= clr_q + TW'(1);
			if (state_q == bba_pkg::ST_FIN && (!m_tvalid_q || m_tready))
				m_tvalid_q <= 1'b1;
			else if (m_tready)
				m_tvalid_q <= 1'b0;
			unique case (state_q)
				bba_pkg::ST_M_BUD:    ret_q <= bba_pkg::ST_M_UP;
				bba_pkg::ST_M_PUSH:   ret_q <= bba_pkg::ST_FIN;
				bba_pkg::ST_A_SPLIT0: ret_q <= bba_pkg::ST_A_SPLIT1;
				bba_pkg::ST_A_SPLIT1: ret_q <= bba_pkg::ST_A_SPLIT2;
				bba_pkg::ST_A_SPLIT2: ret_q <= bba_pkg::ST_A_SPLIT3;
				bba_pkg::ST_A_TAKE:   ret_q <= bba_pkg::ST_A_MARK;
				default: ;
			endcase
			if (state_q == bba_pkg::ST_P_WR && prev_rd_q[LB] &&
			    prev_rd_q[LB-1:0] <= LB'(LB))
				heads_q[prev_rd_q[LW-1:0]] <= next_rd_q;
			if (state_q == bba_pkg::ST_U_WR0)
				heads_q[push_lvl_q] <= {1'b1, push_node_q};
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		unique case (state_q)
			bba_pkg::ST_IDLE: begin
				cmd_q      <= s_tuser;
				cnt_q      <= s_tdata[15:0];
				size_q     <= s_tdata[31:16];
				aexp_q     <= s_tdata[36:32];
				addr_q     <= s_tdata[68:37];
				res_st_q   <= bba_pkg::STS_OK;
				res_addr_q <= '0;
				res_exp_q  <= '0;
				res_fd_q   <= 1'b0;
			end
			bba_pkg::ST_FIN: begin
				if (!m_tvalid_q || m_tready) begin
					out_st_q   <= res_st_q;
					out_addr_q <= res_addr_q;
					out_exp_q  <= res_exp_q;
					out_fd_q   <= res_fd_q;
				end
			end
			bba_pkg::ST_F_ROOTCK: if (!tree_rd_q) res_st_q <= bba_pkg::STS_INVALID;
			bba_pkg::ST_F_START: begin
				node_q <= off[MAX_EXP-1:MIN_EXP];
				lvl_q  <= '0;
				if (off[31:MAX_EXP] != '0 && cmd_q == bba_pkg::CMD_FREE)
					res_st_q <= bba_pkg::STS_INVALID;
			end
			bba_pkg::ST_F_CK: begin
				if (!tree_rd_q) begin
					if (lvl_q == LW'(LB)) begin
						if (cmd_q == bba_pkg::CMD_FREE) res_st_q <= bba_pkg::STS_INVALID;
					end else begin
						lvl_q  <= lvl_q + LW'(1);
						node_q <= node_q & (~LB'(0) << (lvl_q + LW'(1)));
					end
				end
			end
			bba_pkg::ST_F_C1, bba_pkg::ST_F_C2: begin
				if (tree_rd_q && cmd_q == bba_pkg::CMD_FREE) res_st_q <= bba_pkg::STS_INVALID;
			end
			bba_pkg::ST_F_HIT: begin
				if (cmd_q == bba_pkg::CMD_FREE && strict_q && addr_q != blk_base) begin
					res_st_q <= bba_pkg::STS_NOT_BASE;
				end else begin
					res_addr_q <= blk_base;
					res_exp_q  <= EXP_W'(lvl_q) + EXP_W'(MIN_EXP);
					res_fd_q   <= 1'b1;
				end
			end
			bba_pkg::ST_M_BUD: pop_q <= buddy;
			bba_pkg::ST_M_UP: begin
				node_q <= node_q & ~lvl_bit;
				lvl_q  <= lvl_q + LW'(1);
			end
			bba_pkg::ST_M_PUSH: begin
				push_lvl_q  <= lvl_q;
				push_node_q <= node_q;
			end
			bba_pkg::ST_A_MUL: prod_q <= 32'(cnt_q) * 32'(size_q);
			bba_pkg::ST_A_NEED: begin
				need_q <= need_c;
				lvl_q  <= '0;
				if ({2'b0, prod_q} > REGION_SZ || need_c > REGION_SZ)
					res_st_q <= bba_pkg::STS_NOMEM;
			end
			bba_pkg::ST_A_LVL: begin
				if (need_q > (34'(1) << (lvl_q + LW'(MIN_EXP)))) lvl_q <= lvl_q + LW'(1);
				else i_q <= lvl_q;
			end
			bba_pkg::ST_A_SRCH: begin
				if (!head_rd[LB]) begin
					if (i_q == LW'(LB)) res_st_q <= bba_pkg::STS_NOMEM;
					else i_q <= i_q + LW'(1);
				end
			end
			bba_pkg::ST_A_SPLIT0: begin
				w_q   <= head_rd[LB-1:0];
				pop_q <= head_rd[LB-1:0];
			end
			bba_pkg::ST_A_SPLIT1: begin
				push_lvl_q  <= i_q - LW'(1);
				push_node_q <= w_q ^ (LB'(1) << (i_q - LW'(1)));
			end
			bba_pkg::ST_A_SPLIT2: begin
				push_lvl_q  <= i_q - LW'(1);
				push_node_q <= w_q;
			end
			bba_pkg::ST_A_SPLIT3: i_q <= i_q - LW'(1);
			bba_pkg::ST_A_TAKE: begin
				node_q <= head_rd[LB-1:0];
				pop_q  <= head_rd[LB-1:0];
			end
			bba_pkg::ST_A_MARK: begin
				res_addr_q <= r_c + ((32'(0) - r_c) & mask_c);
				res_exp_q  <= EXP_W'(lvl_q) + EXP_W'(MIN_EXP);
				res_fd_q   <= 1'b1;
			end
			bba_pkg::ST_U_WR0: old_q <= head_rd;
			default: ;
		endcase
	end

	localparam int EXP_W = bba_pkg::EXP_W;

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {1'b0, out_exp_q, out_addr_q, out_st_q};
	assign m_tuser  = out_fd_q;

	a_found_ok: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser |-> m_tdata[1:0] == bba_pkg::STS_OK)
		else $error("found result with error status");

	a_miss_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tuser |-> m_tdata[38:2] == '0)
		else $error("missing result carries address or size");

	a_exp_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser |-> m_tdata[38:34] >= 5'(MIN_EXP) &&
			m_tdata[38:34] <= 5'(MAX_EXP))
		else $error("block size out of range");

	a_clear_busy: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == bba_pkg::ST_CLEAR |-> !s_tready && !m_tvalid)
		else $error("activity during tree clear");

endmodule
